// ----- rtl/orqa_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// orqa_pkg
// Shared types and constants for the overwrite ring queue with running mean.
// ----------------------------------------------------------------------------
package orqa_pkg;

    localparam int TAG_W     = 16;
    localparam int YEAR_W    = 14;
    localparam int CNT_W     = 6;
    localparam int SUM_W     = 20;
    localparam int DIV_BITS  = 2;
    localparam int DIV_STEPS = SUM_W / DIV_BITS;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_DONE
    } state_t;

    typedef struct packed {
        op_t               operation;
        logic [TAG_W-1:0]  item_tag;
        logic [YEAR_W-1:0] entry_year;
    } in_item_t;

    typedef struct packed {
        status_t           status;
        logic [YEAR_W-1:0] mean_year;
        logic [TAG_W-1:0]  removed_tag;
        logic [YEAR_W-1:0] removed_year;
        logic [CNT_W-1:0]  entry_count;
    } out_item_t;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [YEAR_W-1:0] year;
    } entry_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic div_step;
        logic out_load;
    } ctl_cmd_t;

    typedef struct packed {
        logic is_insert;
        logic div_last;
        logic out_free;
    } ctl_stat_t;

endpackage
`default_nettype wire

// ----- rtl/orqa_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// orqa_ctrl
// Sequencer: accept, update the ring, run the mean division, hand off result.
// ----------------------------------------------------------------------------
module orqa_ctrl
    import orqa_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    output ctl_cmd_t       cmd,
    input  wire ctl_stat_t stat
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = stat.is_insert ? S_DIV : S_DONE;
            end
            S_DIV: begin
                if (stat.div_last) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            S_EXEC: begin
                cmd.exec = 1'b1;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
            end
            S_DONE: begin
                cmd.out_load = stat.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/orqa_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// orqa_datapath
// Entry memory, ring pointers, running sum, radix-4 divider, result register.
// ----------------------------------------------------------------------------
module orqa_datapath
    import orqa_pkg::*;
#(
    parameter int SLOTS = 6
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data,
    input  wire ctl_cmd_t  cmd,
    output ctl_stat_t      stat
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOTS - 1);

    entry_t            mem [SLOTS];
    entry_t            rd_reg;
    in_item_t          in_reg;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  dvs_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    status_t           res_status_reg;
    logic [TAG_W-1:0]  res_tag_reg;
    logic [YEAR_W-1:0] res_year_reg;
    logic              m_valid_reg;
    out_item_t         m_data_reg;

    logic              ins;
    logic              full;
    logic              empty;
    logic              drop;
    logic [SUM_W-1:0]  sum_drop;
    logic [CNT_W:0]    trial;

    // memory: write at tail, registered read at head
    always_ff @(posedge aclk) begin
        if (cmd.exec && ins) begin
            mem[tail_reg] <= entry_t'{tag: in_reg.item_tag, year: in_reg.entry_year};
        end
        rd_reg <= mem[head_reg];
    end

    assign ins   = (in_reg.operation == OP_INSERT);
    assign full  = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);
    assign drop  = ins ? full : !empty;

    always_comb begin
        sum_drop   = sum_reg - (drop ? SUM_W'(rd_reg.year) : '0);
        sum_next   = ins ? sum_drop + SUM_W'(in_reg.entry_year) : sum_drop;
        head_next  = drop ? ((head_reg == LAST_IDX) ? '0 : head_reg + 1'b1) : head_reg;
        tail_next  = ins ? ((tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1) : tail_reg;
        if (ins) begin
            count_next = full ? count_reg : count_reg + 1'b1;
        end else begin
            count_next = empty ? count_reg : count_reg - 1'b1;
        end
    end

    // two quotient bits per step
    always_comb begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        trial    = '0;
        for (int k = 0; k < DIV_BITS; k++) begin
            trial    = {rem_next, quo_next[SUM_W-1]};
            quo_next = {quo_next[SUM_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next    = CNT_W'(trial - {1'b0, dvs_reg});
                quo_next[0] = 1'b1;
            end else begin
                rem_next = trial[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.exec) begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
                sum_reg   <= sum_next;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_reg <= s_data;
        end
        if (cmd.exec) begin
            rem_reg  <= '0;
            quo_reg  <= sum_next;
            dvs_reg  <= count_next;
            dcnt_reg <= '0;
            if (ins) begin
                res_status_reg <= ST_INSERTED;
                res_tag_reg    <= '0;
                res_year_reg   <= '0;
            end else if (empty) begin
                res_status_reg <= ST_EMPTY;
                res_tag_reg    <= '0;
                res_year_reg   <= '0;
            end else begin
                res_status_reg <= ST_REMOVED;
                res_tag_reg    <= rd_reg.tag;
                res_year_reg   <= rd_reg.year;
            end
        end else if (cmd.div_step) begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            dcnt_reg <= dcnt_reg + 1'b1;
        end
        if (cmd.out_load) begin
            m_data_reg.status       <= res_status_reg;
            m_data_reg.mean_year    <= (res_status_reg == ST_INSERTED) ?
                                       quo_reg[YEAR_W-1:0] : '0;
            m_data_reg.removed_tag  <= res_tag_reg;
            m_data_reg.removed_year <= res_year_reg;
            m_data_reg.entry_count  <= count_reg;
        end
    end

    assign stat.is_insert = ins;
    assign stat.div_last  = (dcnt_reg == DCNT_W'(DIV_STEPS - 1));
    assign stat.out_free  = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

// ----- rtl/overwrite_ring_queue_average.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// overwrite_ring_queue_average
// Ring queue of SLOTS-1 tagged entries that overwrites the oldest entry when
// full and reports the truncated mean of the held years after each insert.
// ----------------------------------------------------------------------------
// One transaction at a time. A remove passes through the execute and done
// states before the next acceptance; an insert also passes through the
// running-sum divider, which retires two quotient bits per cycle over the
// 20-bit sum (10 steps). The result sits in an output register, so a new
// transaction is taken while the previous result waits for m_ready. Removing
// from an empty queue returns the empty status and changes nothing; an insert
// into a full queue drops the oldest entry without reporting it.
// ----------------------------------------------------------------------------
module overwrite_ring_queue_average
    import orqa_pkg::*;
#(
    parameter int SLOTS = 6
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_item_t     m_data
);

    ctl_cmd_t  cmd;
    ctl_stat_t stat;

    orqa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    orqa_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule
`default_nettype wire
